>>> hw/rtl/rdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdq_pkg: shared definitions for the reversible deque
// Sizes, command and status codes, and the structs that pass between the
// pointer control and the top level.
// ----------------------------------------------------------------------------
package rdq_pkg;

	// Storage geometry.
	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SUM_W      = $clog2(2 * DEPTH);

	// Port field widths.
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;
	localparam int WORD_W = 32;

	typedef logic [OP_W-1:0]       opcode_t;
	typedef logic [ST_W-1:0]       status_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [CNT_W-1:0]      count_t;
	typedef logic [SUM_W-1:0]      sum_t;
	typedef logic [DATA_WIDTH-1:0] data_t;

	// Command codes.
	localparam opcode_t OP_POP_BACK   = 3'd0;
	localparam opcode_t OP_POP_FRONT  = 3'd1;
	localparam opcode_t OP_REVERSE    = 3'd2;
	localparam opcode_t OP_PUSH_BACK  = 3'd3;
	localparam opcode_t OP_PUSH_FRONT = 3'd4;

	// Result status codes.
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// One access to the ring memory.
	typedef struct packed {
		logic  we;
		addr_t waddr;
		data_t wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	// What a command leaves for the result path.
	typedef struct packed {
		logic    valid;
		status_t status;
		logic    from_mem;
	} res_t;

	// Fold a sum below twice the depth back into the ring.
	function automatic addr_t wrap_sum(input sum_t s);
		sum_t r;
		r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
		return ADDR_W'(r);
	endfunction

endpackage

>>> hw/rtl/rdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdq_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and appears
// in the cycle after the read enable. Contents are not reset.
// ----------------------------------------------------------------------------
module rdq_ram #(
	parameter int DW    = 32,
	parameter int AW    = 10,
	parameter int WORDS = 1024
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [WORDS];
	logic [DW-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/rdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdq_ctrl: deque pointer control
// Holds the head pointer, the entry count and the reverse flag, decodes each
// command into at most one memory access and the status of any result, and
// updates the pointers when the command is accepted.
// ----------------------------------------------------------------------------
module rdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  rdq_pkg::opcode_t  opcode,
	input  logic [31:0]       push_value,
	output rdq_pkg::mem_req_t req,
	output rdq_pkg::res_t     res
);
	import rdq_pkg::*;

	addr_t  head_q;
	count_t count_q;
	logic   rev_q;

	addr_t  head_d;
	count_t count_d;
	logic   rev_d;

	logic   empty;
	logic   full;
	logic   use_front;
	addr_t  head_inc;
	addr_t  head_dec;
	addr_t  tail_idx;
	addr_t  last_idx;
	sum_t   head_ext;
	sum_t   count_ext;

	// Neighbor indexes around the current contents.
	always_comb begin
		head_ext  = SUM_W'(head_q);
		count_ext = SUM_W'(count_q);
		head_inc  = (head_q == ADDR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
		head_dec  = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - 1'b1;
		tail_idx  = wrap_sum(head_ext + count_ext);
		last_idx  = wrap_sum(head_ext + count_ext - 1'b1);
		empty     = (count_q == '0);
		full      = (count_q == CNT_W'(DEPTH));
	end

	// Command decode: memory access, result and next pointer state.
	always_comb begin
		req       = '0;
		res       = '0;
		head_d    = head_q;
		count_d   = count_q;
		rev_d     = rev_q;
		use_front = 1'b0;
		req.wdata = DATA_WIDTH'(push_value);
		case (opcode)
			OP_POP_BACK, OP_POP_FRONT: begin
				res.valid = 1'b1;
				use_front = (opcode == OP_POP_FRONT) ^ rev_q;
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					res.status   = ST_OK;
					res.from_mem = 1'b1;
					req.re       = 1'b1;
					count_d      = count_q - 1'b1;
					if (use_front) begin
						req.raddr = head_q;
						head_d    = head_inc;
					end else begin
						req.raddr = last_idx;
					end
				end
			end
			OP_REVERSE: begin
				rev_d = ~rev_q;
			end
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				use_front = (opcode == OP_PUSH_FRONT) ^ rev_q;
				if (full) begin
					res.valid  = 1'b1;
					res.status = ST_FULL;
				end else begin
					req.we  = 1'b1;
					count_d = count_q + 1'b1;
					if (use_front) begin
						req.waddr = head_dec;
						head_d    = head_dec;
					end else begin
						req.waddr = tail_idx;
					end
				end
			end
			default: begin
				// Unused codes do nothing.
			end
		endcase
		if (!accept) begin
			req.we = 1'b0;
			req.re = 1'b0;
		end
	end

	// Pointer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (accept) begin
			head_q  <= head_d;
			count_q <= count_d;
			rev_q   <= rev_d;
		end
	end

endmodule

>>> hw/rtl/reversible_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reversible_deque: double-ended queue with a reverse command
// Channel   Dir  Handshake            Payload
// input     in   in_valid / in_ready  opcode[2:0], push_value[31:0]
// result    out  out_valid / out_ready status[1:0], pop_value[31:0]
//
// One command is accepted per cycle while in_ready is high. A pop result passes
// from the registered memory read in the read stage into the output register.
// The single read stage sets the rate: a stalled result holds it, and the input
// stalls only while that stage cannot drain.
// Reset clears the pointers, count and reverse flag; the ring memory is not
// cleared, since only pushed entries are ever read.
// ----------------------------------------------------------------------------
module reversible_deque (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rdq_pkg::opcode_t    opcode,
	input  logic [31:0]         push_value,
	output logic                out_valid,
	input  logic                out_ready,
	output rdq_pkg::status_t    status,
	output logic [31:0]         pop_value
);
	import rdq_pkg::*;

	mem_req_t req;
	res_t     res;
	data_t    rdata;
	logic     accept;
	logic     out_free;
	logic     s1_adv;

	logic     s1_valid_q;
	status_t  s1_status_q;
	logic     s1_from_mem_q;
	logic     out_valid_q;
	status_t  status_q;
	logic [WORD_W-1:0] pop_value_q;

	// Handshake: the read stage drains into a free output register.
	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = s1_valid_q && out_free;
	assign in_ready = !s1_valid_q || out_free;
	assign accept   = in_valid && in_ready;

	rdq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (opcode),
		.push_value (push_value),
		.req        (req),
		.res        (res)
	);

	rdq_ram #(
		.DW    (DATA_WIDTH),
		.AW    (ADDR_W),
		.WORDS (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.we),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.re    (req.re),
		.raddr (req.raddr),
		.rdata (rdata)
	);

	// Read stage: a result waits here while its memory read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= accept && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_status_q   <= res.status;
			s1_from_mem_q <= res.from_mem;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_q    <= s1_status_q;
			pop_value_q <= s1_from_mem_q ? WORD_W'(rdata) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign pop_value = pop_value_q;

endmodule

>>> sim/reversible_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reversible_deque_tb: self-checking testbench for the reversible deque
// Commands go in through a valid/ready sender with random gaps, and results
// are taken by a receiver that stalls at random. A mirror of the deque,
// updated as each command is accepted, predicts every pop result and every
// refused push. Each result is compared field by field with the oldest
// prediction. The run covers the empty and full edges, both ring wraps and
// the reverse flag, and random traffic near empty and near full.
// ----------------------------------------------------------------------------
module reversible_deque_tb;
	import rdq_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int MAX_SHOWN   = 40;
	localparam int DRAIN_WAIT  = 20;

	typedef struct packed {
		status_t     status;
		logic [31:0] word;
	} pop_result_t;

	// Ports of the block; the inputs are known from time zero.
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	opcode_t     opcode     = OP_REVERSE;
	logic [31:0] push_value = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	status_t     status;
	logic [31:0] pop_value;

	// Mirror of the deque and the results it predicts.
	data_t       mirror_ring [DEPTH];
	int          mirror_head     = 0;
	int          mirror_count    = 0;
	bit          mirror_reversed = 1'b0;
	pop_result_t expected_pops[$];

	// Bookkeeping.
	int error_count   = 0;
	int items_sent    = 0;
	int out_stall_left = 0;
	int quiet_cycles  = 0;
	bit idle_on       = 1'b1;
	int n_popped = 0, n_empty = 0, n_full = 0, n_pushed = 0, n_reversed = 0;
	int deepest  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	reversible_deque u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.push_value(push_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.pop_value (pop_value)
	);

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Random command with the given shares of pops and pushes; the rest are
	// mostly reverses and a few unused codes.
	function automatic opcode_t random_cmd(input int pop_pct, input int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < pop_pct)
			return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
		else if (r < pop_pct + push_pct)
			return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		else if (r < 97)
			return OP_REVERSE;
		return opcode_t'($urandom_range(5, 7));
	endfunction

	function automatic logic [31:0] random_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 32'h0000_0000;
		else if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom();
	endfunction

	// Append one predicted result behind the ones already waiting.
	task automatic expect_result(input status_t st, input logic [31:0] word);
		expected_pops.insert(expected_pops.size(), pop_result_t'{st, word});
	endtask

	// Apply one accepted command to the mirror and queue what it returns.
	task automatic predict_deque_cmd(input opcode_t op, input logic [31:0] value);
		bit use_front;
		int idx;
		case (op)
			OP_POP_BACK, OP_POP_FRONT: begin
				if (mirror_count == 0) begin
					expect_result(ST_EMPTY, 32'd0);
					n_empty++;
				end else begin
					// A set reverse flag swaps the physical end used.
					use_front = (op == OP_POP_FRONT) != mirror_reversed;
					if (use_front) begin
						idx = mirror_head;
						mirror_head = (mirror_head + 1) % DEPTH;
					end else begin
						idx = (mirror_head + mirror_count - 1) % DEPTH;
					end
					mirror_count--;
					expect_result(ST_OK, 32'(mirror_ring[idx]));
					n_popped++;
				end
			end
			OP_REVERSE: begin
				mirror_reversed = !mirror_reversed;
				n_reversed++;
			end
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (mirror_count >= DEPTH) begin
					expect_result(ST_FULL, 32'd0);
					n_full++;
				end else begin
					use_front = (op == OP_PUSH_FRONT) != mirror_reversed;
					if (use_front) begin
						mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
						mirror_ring[mirror_head] = data_t'(value);
					end else begin
						mirror_ring[(mirror_head + mirror_count) % DEPTH] = data_t'(value);
					end
					mirror_count++;
					n_pushed++;
					if (mirror_count > deepest)
						deepest = mirror_count;
				end
			end
			default: begin
				// Unused codes are ignored by the block.
			end
		endcase
	endtask

	// Send one command; valid stays up across back-to-back items.
	task automatic send_cmd(input opcode_t op, input logic [31:0] value);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		push_value <= value;
		do
			@(posedge clk);
		while (!in_ready);
		predict_deque_cmd(op, value);
		items_sent++;
		// Switch idling on and off so some stretches run at full rate.
		if (items_sent % 97 == 0)
			idle_on = ($urandom_range(0, 3) != 0);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		error_count++;
		if (error_count <= MAX_SHOWN)
			$display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
	endtask

	// Result checker and receiver stalls.
	always @(posedge clk) begin
		pop_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pops.size() == 0) begin
				report_mismatch("unexpected result, status", '0, 32'(status));
			end else begin
				want = expected_pops[0];
				expected_pops.delete(0);
				if (status !== want.status)
					report_mismatch("status", 32'(want.status), 32'(status));
				if (pop_value !== want.word)
					report_mismatch("pop_value", want.word, pop_value);
			end
		end
		if (out_stall_left > 0) begin
			out_ready <= 1'b0;
			out_stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (idle_on)
				out_stall_left = pick_gap();
		end
	end

	// Watchdog on cycles with no handshake on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Pops on an empty deque, pushes at both ends with the head wrapping
	// below zero, reverse in both directions, and the unused codes.
	task automatic test_ends_and_reverse();
		idle_on = 1'b0;
		send_cmd(OP_POP_BACK, 32'h0000_0000);
		send_cmd(OP_POP_FRONT, 32'hFFFF_FFFF);
		send_cmd(OP_PUSH_BACK, 32'h0000_0000);
		send_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF);
		send_cmd(OP_PUSH_BACK, 32'hA5A5_A5A5);
		send_cmd(OP_POP_FRONT, 32'h0000_0000);
		send_cmd(OP_REVERSE, 32'hFFFF_FFFF);
		send_cmd(OP_PUSH_FRONT, 32'h1234_5678);
		send_cmd(OP_POP_BACK, 32'h0000_0000);
		send_cmd(OP_POP_FRONT, 32'h0000_0000);
		send_cmd(OP_REVERSE, 32'h0000_0000);
		send_cmd(OP_POP_BACK, 32'h0000_0000);
		send_cmd(OP_POP_BACK, 32'h0000_0000);
		send_cmd(OP_POP_FRONT, 32'h0000_0000);
		send_cmd(opcode_t'(5), 32'hFFFF_FFFF);
		send_cmd(opcode_t'(6), 32'h5555_AAAA);
		send_cmd(opcode_t'(7), 32'hFFFF_FFFF);
		send_cmd(OP_POP_BACK, 32'h0000_0000);
		// Push then pop at once, back to back, so the read of an entry directly
		// follows its write.
		send_cmd(OP_PUSH_BACK, 32'hDEAD_BEEF);
		send_cmd(OP_POP_BACK, 32'h0000_0000);
		send_cmd(OP_PUSH_FRONT, 32'h8000_0001);
		send_cmd(OP_POP_BACK, 32'h0000_0000);
		idle_on = 1'b1;
	endtask

	// Balanced traffic that keeps the deque shallow and often empty.
	task automatic test_random_near_empty(input int count);
		opcode_t op;
		int n;
		n = 0;
		while (n < count) begin
			op = random_cmd(46, 46);
			send_cmd(op, random_word());
			if (op <= OP_PUSH_FRONT)
				n++;
		end
	endtask

	// Fill to capacity from both ends, then push into the full deque.
	task automatic test_fill_to_full();
		opcode_t op;
		while (mirror_count < DEPTH) begin
			if ($urandom_range(0, 99) < 4)
				op = OP_REVERSE;
			else
				op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			send_cmd(op, random_word());
		end
		send_cmd(OP_PUSH_BACK, random_word());
		send_cmd(OP_PUSH_FRONT, random_word());
		send_cmd(OP_REVERSE, random_word());
		send_cmd(OP_PUSH_BACK, random_word());
		send_cmd(OP_PUSH_FRONT, random_word());
	endtask

	// Push-leaning traffic that keeps hitting the full edge.
	task automatic test_random_near_full(input int count);
		opcode_t op;
		int n;
		n = 0;
		while (n < count) begin
			op = random_cmd(40, 52);
			send_cmd(op, random_word());
			if (op <= OP_PUSH_FRONT)
				n++;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ends_and_reverse();
		test_random_near_empty(350);
		test_fill_to_full();
		test_random_near_full(150);
		in_valid <= 1'b0;

		// Let every predicted result arrive, then watch for strays.
		while (expected_pops.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("ran %0d commands: %0d data pops, %0d empty pops, %0d refused pushes",
			items_sent, n_popped, n_empty, n_full);
		$display("%0d words stored, %0d reverses, deepest fill %0d of %0d, %0d mismatches",
			n_pushed, n_reversed, deepest, DEPTH, error_count);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
